/* design/assert_macros.svh */
// Assertion macros shared by the hold-time buffer RTL.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant violated");

// Consequent holds at the same edge as the antecedent.
`define ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

// Consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

/* design/bhtb_pkg.sv */
// Package for the button hold-time buffer: widths, request kinds and key codes.
// No dependencies.
`default_nettype none

package bhtb_pkg;

   localparam int COUNT_LIMIT_DEFAULT = 32767;
   localparam int NUM_INPUTS          = 14;
   localparam int DIR_COUNT           = 4;
   localparam int REQ_DATA_W          = 24;
   localparam int RSP_DATA_W          = 32;
   localparam int KEY_STATE_W         = 16;
   localparam int LAST_DIR_W          = 15;

   typedef logic [5:0] key_code_type;
   typedef logic [3:0] input_idx_type;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam input_idx_type IDX_BACK    = 4'd0;
   localparam input_idx_type IDX_DOWN    = 4'd1;
   localparam input_idx_type IDX_FORWARD = 4'd2;
   localparam input_idx_type IDX_UP      = 4'd3;
   localparam input_idx_type IDX_BTN_A   = 4'd4;

   localparam key_code_type KEY_B      = 6'd0;
   localparam key_code_type KEY_D      = 6'd1;
   localparam key_code_type KEY_F      = 6'd2;
   localparam key_code_type KEY_U      = 6'd3;
   localparam key_code_type KEY_DB     = 6'd4;
   localparam key_code_type KEY_UB     = 6'd5;
   localparam key_code_type KEY_DF     = 6'd6;
   localparam key_code_type KEY_UF     = 6'd7;
   localparam key_code_type KEY_BS     = 6'd8;
   localparam key_code_type KEY_DS     = 6'd9;
   localparam key_code_type KEY_FS     = 6'd10;
   localparam key_code_type KEY_US     = 6'd11;
   localparam key_code_type KEY_DBS    = 6'd12;
   localparam key_code_type KEY_UBS    = 6'd13;
   localparam key_code_type KEY_DFS    = 6'd14;
   localparam key_code_type KEY_UFS    = 6'd15;
   localparam key_code_type KEY_BTN_A  = 6'd16;
   localparam key_code_type KEY_NB     = 6'd26;
   localparam key_code_type KEY_NBS    = 6'd34;
   localparam key_code_type KEY_NDS    = 6'd35;
   localparam key_code_type KEY_NFS    = 6'd36;
   localparam key_code_type KEY_NUS    = 6'd37;
   localparam key_code_type KEY_NDBS   = 6'd38;
   localparam key_code_type KEY_NUBS   = 6'd39;
   localparam key_code_type KEY_NDFS   = 6'd40;
   localparam key_code_type KEY_NUFS   = 6'd41;
   localparam key_code_type KEY_LIMIT  = 6'd52;

endpackage

`default_nettype wire

/* design/button_hold_time_buffer.sv */
// Button hold-time buffer: each accepted request is registered into the response register
// or the skid entry. Throughput one request per cycle while the skid entry is empty; a two-entry
// output (register plus skid) accepts one more request while the response side stalls.
// Synchronous active-high reset clears all hold counters to 0, all inputs to
// released, and empties the output stage.
// Depends on bhtb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module button_hold_time_buffer #(
   parameter int COUNT_LIMIT = bhtb_pkg::COUNT_LIMIT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [13:0] pad_bits, [14] facing_left, [20:15] key_code, [21] second_rule, [23:22] zero
   input  wire logic [bhtb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] key_state, [30:16] last_dir_time, [31] zero
   output logic [bhtb_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import bhtb_pkg::*;

   localparam int CNT_W = $clog2(longint'(COUNT_LIMIT) + 1) + 1;
   localparam int EXT_W = (CNT_W > KEY_STATE_W) ? CNT_W : KEY_STATE_W;

   typedef logic signed [CNT_W-1:0] cnt_type;

   localparam cnt_type LIM_POS = cnt_type'(COUNT_LIMIT);
   localparam cnt_type LIM_NEG = -LIM_POS;
   localparam cnt_type ONE     = cnt_type'(1);

   function automatic cnt_type smax(input cnt_type p, input cnt_type q);
      return (p > q) ? p : q;
   endfunction

   function automatic cnt_type smin(input cnt_type p, input cnt_type q);
      return (p < q) ? p : q;
   endfunction

   function automatic cnt_type sabs(input cnt_type p);
      return (p < 0) ? -p : p;
   endfunction

   function automatic cnt_type pick_neg(input cnt_type p, input cnt_type q, input cnt_type r);
      cnt_type res;
      if (p > 0) begin
         res = -smax(q, r);
      end else if (q > 0) begin
         res = -smax(p, r);
      end else if (r > 0) begin
         res = -smax(p, q);
      end else begin
         res = -smax(p, smax(q, r));
      end
      return res;
   endfunction

   cnt_type [NUM_INPUTS-1:0] cnt_ff, cnt_in;
   logic [NUM_INPUTS-1:0]    pressed_ff, pressed_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0]    out_data_ff, out_data_in;
   logic [RSP_DATA_W-1:0]    skid_data_ff, skid_data_in;

   logic                     req_acc, rsp_take, is_frame;
   logic [13:0]              pad_bits;
   logic                     facing_left, second_rule;
   key_code_type             key_code, base_code;
   logic [NUM_INPUTS-1:0]    level;

   cnt_type bb, db, fb, ub;
   cnt_type p_b, p_d, p_f, p_u, p_db, p_ub, p_df, p_uf, p_dbs, p_ubs, p_dfs, p_ufs;
   cnt_type base_val, plain_val, alt_val, ks_val, ldt_val, dir_abs;
   logic signed [EXT_W-1:0] ks_ext, ldt_ext;
   logic [RSP_DATA_W-1:0]   new_data;

   assign pad_bits    = req_tdata[13:0];
   assign facing_left = req_tdata[14];
   assign key_code    = req_tdata[20:15];
   assign second_rule = req_tdata[21];

   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;
   assign is_frame   = req_acc && (req_tuser == KIND_FRAME);

   // advance counters on a frame request
   always_comb begin
      level[IDX_BACK]    = facing_left ? pad_bits[3] : pad_bits[2];
      level[IDX_DOWN]    = pad_bits[1];
      level[IDX_FORWARD] = facing_left ? pad_bits[2] : pad_bits[3];
      level[IDX_UP]      = pad_bits[0];
      level[NUM_INPUTS-1:DIR_COUNT] = pad_bits[13:DIR_COUNT];
      cnt_in     = cnt_ff;
      pressed_in = pressed_ff;
      if (is_frame) begin
         for (int i = 0; i < NUM_INPUTS; i++) begin
            pressed_in[i] = level[i];
            if (level[i] != pressed_ff[i]) begin
               cnt_in[i] = level[i] ? ONE : -ONE;
            end else if (pressed_ff[i]) begin
               cnt_in[i] = (cnt_ff[i] < LIM_POS) ? cnt_ff[i] + ONE : cnt_ff[i];
            end else begin
               cnt_in[i] = (cnt_ff[i] > LIM_NEG) ? cnt_ff[i] - ONE : cnt_ff[i];
            end
         end
      end
   end

   // derive direction states from the post-update counters
   always_comb begin
      bb = cnt_in[IDX_BACK];
      db = cnt_in[IDX_DOWN];
      fb = cnt_in[IDX_FORWARD];
      ub = cnt_in[IDX_UP];
      p_b   = -smax(smax(db, ub), bb);
      p_d   = -smax(smax(bb, fb), db);
      p_f   = -smax(smax(db, ub), fb);
      p_u   = -smax(smax(bb, fb), ub);
      p_db  = smin(db, bb);
      p_ub  = smin(ub, bb);
      p_df  = smin(db, fb);
      p_uf  = smin(ub, fb);
      p_dbs = -smax(smax(ub, fb), smax(db, bb));
      p_ubs = -smax(smax(db, fb), smax(ub, bb));
      p_dfs = -smax(smax(ub, bb), smax(db, fb));
      p_ufs = -smax(smax(db, bb), smax(ub, fb));
   end

   // plain rule: fold negated codes onto their base code
   always_comb begin
      base_code = (key_code >= KEY_NB) ? key_code - KEY_NB : key_code;
      case (base_code)
         KEY_B:   base_val = p_b;
         KEY_D:   base_val = p_d;
         KEY_F:   base_val = p_f;
         KEY_U:   base_val = p_u;
         KEY_DB:  base_val = p_db;
         KEY_UB:  base_val = p_ub;
         KEY_DF:  base_val = p_df;
         KEY_UF:  base_val = p_uf;
         KEY_BS:  base_val = bb;
         KEY_DS:  base_val = db;
         KEY_FS:  base_val = fb;
         KEY_US:  base_val = ub;
         KEY_DBS: base_val = p_dbs;
         KEY_UBS: base_val = p_ubs;
         KEY_DFS: base_val = p_dfs;
         KEY_UFS: base_val = p_ufs;
         default: base_val = cnt_in[input_idx_type'(base_code - KEY_BTN_A) + IDX_BTN_A];
      endcase
      if (key_code >= KEY_LIMIT) begin
         plain_val = '0;
      end else if (key_code >= KEY_NB) begin
         plain_val = -base_val;
      end else begin
         plain_val = base_val;
      end
   end

   // alternate rule for strict and negated strict codes
   always_comb begin
      case (key_code)
         KEY_BS:   alt_val = (bb < 0) ? bb : smin(sabs(bb), smin(sabs(db), sabs(ub)));
         KEY_DS:   alt_val = (db < 0) ? db : smin(sabs(db), smin(sabs(bb), sabs(fb)));
         KEY_FS:   alt_val = (fb < 0) ? fb : smin(sabs(fb), smin(sabs(db), sabs(ub)));
         KEY_US:   alt_val = (ub < 0) ? ub : smin(sabs(ub), smin(sabs(bb), sabs(fb)));
         KEY_DBS:  alt_val = (p_dbs < 0) ? p_dbs : smin(sabs(db), sabs(bb));
         KEY_UBS:  alt_val = (p_ubs < 0) ? p_ubs : smin(sabs(ub), sabs(bb));
         KEY_DFS:  alt_val = (p_dfs < 0) ? p_dfs : smin(sabs(db), sabs(fb));
         KEY_UFS:  alt_val = (p_ufs < 0) ? p_ufs : smin(sabs(ub), sabs(fb));
         KEY_NBS:  alt_val = pick_neg(p_b, p_db, p_ub);
         KEY_NDS:  alt_val = pick_neg(p_d, p_db, p_df);
         KEY_NFS:  alt_val = pick_neg(p_f, p_df, p_uf);
         KEY_NUS:  alt_val = pick_neg(p_u, p_ub, p_uf);
         KEY_NDBS: alt_val = pick_neg(p_db, p_dbs, p_b);
         KEY_NUBS: alt_val = pick_neg(p_ub, p_ubs, p_u);
         KEY_NDFS: alt_val = pick_neg(p_df, p_dfs, p_d);
         KEY_NUFS: alt_val = pick_neg(p_uf, p_ufs, p_u);
         default:  alt_val = plain_val;
      endcase
   end

   // smallest nonzero magnitude of the four plain direction states
   always_comb begin
      ldt_val = '0;
      for (int i = 0; i < DIR_COUNT; i++) begin
         case (i)
            0:       dir_abs = sabs(p_b);
            1:       dir_abs = sabs(p_d);
            2:       dir_abs = sabs(p_f);
            default: dir_abs = sabs(p_u);
         endcase
         if ((dir_abs != 0) && ((ldt_val == 0) || (dir_abs < ldt_val))) begin
            ldt_val = dir_abs;
         end
      end
   end

   assign ks_val   = (req_tuser == KIND_QUERY) ? (second_rule ? alt_val : plain_val) : '0;
   assign ks_ext   = EXT_W'(ks_val);
   assign ldt_ext  = EXT_W'(ldt_val);
   assign new_data = {1'b0, ldt_ext[LAST_DIR_W-1:0], ks_ext[KEY_STATE_W-1:0]};

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_acc;
            out_data_in  = new_data;
         end
      end else if (req_acc) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         pressed_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         pressed_ff    <= pressed_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_accept_fills_out, req_acc, out_valid_ff)
   `ASSERT_NEXT(a_query_keeps_counters, req_acc && (req_tuser == KIND_QUERY), cnt_ff == $past(cnt_ff))

   for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_chk
      `ASSERT_ALWAYS(a_sign_matches_level, pressed_ff[g] ? (cnt_ff[g] > 0) : (cnt_ff[g] <= 0))
   end

endmodule

`default_nettype wire
